// ===== hdl/cfl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cfl_pkg;

    // Most results one input item can cause: a finished token, the token or
    // error of the byte itself, and the End token or the empty-formula error.
    localparam int MAX_RESULTS = 3;
    localparam int COUNT_BITS  = 2;

    // Token kinds.
    localparam logic [3:0] KIND_ELEMENT  = 4'd0;
    localparam logic [3:0] KIND_NUMBER   = 4'd1;
    localparam logic [3:0] KIND_LPAREN   = 4'd2;
    localparam logic [3:0] KIND_RPAREN   = 4'd3;
    localparam logic [3:0] KIND_LBRACKET = 4'd4;
    localparam logic [3:0] KIND_RBRACKET = 4'd5;
    localparam logic [3:0] KIND_STAR     = 4'd6;
    localparam logic [3:0] KIND_END      = 4'd7;
    localparam logic [3:0] KIND_ERROR    = 4'd8;

    // Error codes.
    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_WHITESPACE   = 3'd1;
    localparam logic [2:0] ERR_UNEXPECTED   = 3'd2;
    localparam logic [2:0] ERR_ZERO         = 3'd3;
    localparam logic [2:0] ERR_LEADING_ZERO = 3'd4;
    localparam logic [2:0] ERR_OVERFLOW     = 3'd5;
    localparam logic [2:0] ERR_EMPTY        = 3'd6;

    // Single-character tokens and the zero digit.
    localparam logic [7:0] CH_LPAREN   = 8'h28;
    localparam logic [7:0] CH_RPAREN   = 8'h29;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_STAR     = 8'h2A;
    localparam logic [7:0] CH_ZERO     = 8'h30;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       ends_formula;
        logic       no_char;
    } lex_item_t;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [2:0]  error_code;
        logic [15:0] start_offset;
        logic [7:0]  token_length;
        logic [23:0] element_text;
        logic [63:0] number_value;
        logic        last_of_run;
    } token_t;

    // All results of one item, oldest in slot 0.
    typedef struct packed {
        logic [COUNT_BITS-1:0]    count;
        token_t [MAX_RESULTS-1:0] slot;
    } bundle_t;

endpackage

`default_nettype wire

// ===== hdl/chemical_formula_lexer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one input beat per cycle while each beat causes at most one result and
// the receiver does not stall; a beat causing more results (up to three) holds back the
// next beat until its last result leaves the result queue.
// Reset: rst_n is asynchronous and active low; it clears the lexer state, the input
// register and the result queue, and the block is ready as soon as it is released.
module chemical_formula_lexer_unit #(
    parameter int OFFSET_BITS   = 16,
    parameter int ELEMENT_CHARS = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  cfl_pkg::lex_item_t item,
    output logic               token_valid,
    input  logic               token_stall,
    output cfl_pkg::token_t    token
);

    import cfl_pkg::*;

    // The input register holds one beat while the result queue still drains, so a
    // new character is taken even when a finished token waits at the output.
    logic      in_valid_reg, in_valid_next;
    lex_item_t in_item_reg, in_item_next;

    logic      room;
    logic      advance;
    bundle_t   bundle;

    // The held beat moves through the lexer step exactly when its results can be
    // loaded into the result queue; the lexer state advances in the same cycle.
    assign advance    = in_valid_reg && room;
    assign item_stall = in_valid_reg && !room;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (!item_stall) begin
            in_valid_next = item_valid;
            if (item_valid) begin
                in_item_next = item;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        in_item_reg <= in_item_next;
    end

    // The lexer step: character classes, the decimal accumulate (times ten plus
    // digit, with a 64-bit overflow check) and every result of the beat in one pass.
    cfl_core #(
        .OFFSET_BITS   (OFFSET_BITS),
        .ELEMENT_CHARS (ELEMENT_CHARS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (in_item_reg),
        .take   (advance),
        .bundle (bundle)
    );

    // The result queue presents a beat's results one per cycle unless the receiver stalls.
    cfl_outq u_outq (
        .clk         (clk),
        .rst_n       (rst_n),
        .bundle      (bundle),
        .load        (advance),
        .room        (room),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token       (token)
    );

    // A beat that causes results shows its first one in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && bundle.count != 2'd0) |=> token_valid)
        else $error("results of an advanced beat did not reach the output");

    // Only the final result of a two-result beat closes the run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && bundle.count == 2'd2) |->
            (bundle.slot[1].last_of_run && !bundle.slot[0].last_of_run))
        else $error("run end marked on the wrong result");

    // A result taken without the run end mark is followed by another result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (token_valid && !token_stall && !token.last_of_run) |=> token_valid)
        else $error("result run broken before its last result");

endmodule

`default_nettype wire

// ===== hdl/cfl_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cfl_core #(
    parameter int OFFSET_BITS   = 16,
    parameter int ELEMENT_CHARS = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cfl_pkg::lex_item_t item,
    input  logic               take,
    output cfl_pkg::bundle_t   bundle
);

    import cfl_pkg::*;

    localparam int LW = 8 * ELEMENT_CHARS;
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_ELEM,
        MODE_NUM,
        MODE_ERR
    } mode_t;

    mode_t                  mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] byte_offset_reg, byte_offset_next;
    logic [OFFSET_BITS-1:0] token_start_reg, token_start_next;
    logic [7:0]             run_length_reg, run_length_next;
    logic [LW-1:0]          letters_kept_reg, letters_kept_next;
    logic [63:0]            value_accum_reg, value_accum_next;
    logic                   first_digit_zero_reg, first_digit_zero_next;
    logic                   value_overflowed_reg, value_overflowed_next;

    logic [7:0]             c;
    logic                   is_space, is_upper, is_lower, is_digit;
    logic [63:0]            digit_base;
    logic [67:0]            digit_sum;
    logic                   digit_ovf;
    logic [COUNT_BITS-1:0]  cnt;
    token_t [MAX_RESULTS-1:0] slots;
    logic [2:0]             fin_code;
    logic [3:0]             punct_kind;

    function automatic token_t make_tok(
        input logic [3:0]  kind,
        input logic [2:0]  err,
        input logic [31:0] off,
        input logic [7:0]  len,
        input logic [63:0] text,
        input logic [63:0] val
    );
        token_t t;
        t.token_kind   = kind;
        t.error_code   = err;
        t.start_offset = off[15:0];
        t.token_length = len;
        t.element_text = text[23:0];
        t.number_value = val;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

    assign c        = item.char_byte;
    assign is_space = (c == 8'h20) || (c inside {[8'h09:8'h0D]});
    assign is_upper = c inside {[8'h41:8'h5A]};
    assign is_lower = c inside {[8'h61:8'h7A]};
    assign is_digit = c inside {[8'h30:8'h39]};

    // A digit either extends the current number or starts a new one from zero.
    assign digit_base = (mode_reg == MODE_NUM) ? value_accum_reg : 64'd0;
    assign digit_sum  = ({4'd0, digit_base} << 3) + ({4'd0, digit_base} << 1)
                      + 68'(c[3:0]);
    assign digit_ovf  = (digit_sum[67:64] != 4'd0);

    always_comb begin
        case (c)
            CH_LPAREN:   punct_kind = KIND_LPAREN;
            CH_RPAREN:   punct_kind = KIND_RPAREN;
            CH_LBRACKET: punct_kind = KIND_LBRACKET;
            CH_RBRACKET: punct_kind = KIND_RBRACKET;
            CH_STAR:     punct_kind = KIND_STAR;
            default:     punct_kind = KIND_ERROR;
        endcase
    end

    always_comb begin
        mode_next             = mode_reg;
        byte_offset_next      = byte_offset_reg;
        token_start_next      = token_start_reg;
        run_length_next       = run_length_reg;
        letters_kept_next     = letters_kept_reg;
        value_accum_next      = value_accum_reg;
        first_digit_zero_next = first_digit_zero_reg;
        value_overflowed_next = value_overflowed_reg;
        cnt                   = '0;
        slots                 = '0;
        fin_code              = ERR_NONE;

        if (!item.no_char) begin
            if (mode_reg == MODE_ELEM && is_lower) begin
                for (int i = 0; i < ELEMENT_CHARS; i++) begin
                    if (run_length_reg == 8'(i)) begin
                        letters_kept_next[8*(ELEMENT_CHARS-1-i) +: 8] =
                            letters_kept_reg[8*(ELEMENT_CHARS-1-i) +: 8] | c;
                    end
                end
                if (run_length_reg != 8'hFF) begin
                    run_length_next = run_length_reg + 8'd1;
                end
            end else if (mode_reg == MODE_NUM && is_digit) begin
                if (!value_overflowed_reg) begin
                    if (digit_ovf) begin
                        value_overflowed_next = 1'b1;
                    end else begin
                        value_accum_next = digit_sum[63:0];
                    end
                end
                if (run_length_reg != 8'hFF) begin
                    run_length_next = run_length_reg + 8'd1;
                end
            end else begin
                // The byte cannot extend the current token, so close it first.
                if (mode_next == MODE_ELEM) begin
                    slots[cnt] = make_tok(KIND_ELEMENT, ERR_NONE, 32'(token_start_next),
                                          run_length_next, 64'(letters_kept_next), 64'd0);
                    cnt = cnt + 2'd1;
                    mode_next = MODE_IDLE;
                end else if (mode_next == MODE_NUM) begin
                    if (value_overflowed_next) begin
                        fin_code = ERR_OVERFLOW;
                    end else if (value_accum_next == 64'd0) begin
                        fin_code = ERR_ZERO;
                    end else if (first_digit_zero_next) begin
                        fin_code = ERR_LEADING_ZERO;
                    end
                    if (fin_code != ERR_NONE) begin
                        slots[cnt] = make_tok(KIND_ERROR, fin_code, 32'(token_start_next),
                                              run_length_next, 64'd0, 64'd0);
                        mode_next = MODE_ERR;
                    end else begin
                        slots[cnt] = make_tok(KIND_NUMBER, ERR_NONE, 32'(token_start_next),
                                              run_length_next, 64'd0, value_accum_next);
                        mode_next = MODE_IDLE;
                    end
                    cnt = cnt + 2'd1;
                end

                if (mode_next == MODE_IDLE) begin
                    if (is_space) begin
                        slots[cnt] = make_tok(KIND_ERROR, ERR_WHITESPACE,
                                              32'(byte_offset_reg), 8'd1, 64'd0, 64'd0);
                        cnt = cnt + 2'd1;
                        mode_next = MODE_ERR;
                    end else if (is_upper) begin
                        token_start_next = byte_offset_reg;
                        letters_kept_next = '0;
                        letters_kept_next[LW-1 -: 8] = c;
                        run_length_next = 8'd1;
                        mode_next = MODE_ELEM;
                    end else if (is_digit) begin
                        token_start_next      = byte_offset_reg;
                        run_length_next       = 8'd1;
                        value_accum_next      = digit_sum[63:0];
                        value_overflowed_next = 1'b0;
                        first_digit_zero_next = (c == CH_ZERO);
                        mode_next             = MODE_NUM;
                    end else if (punct_kind != KIND_ERROR) begin
                        slots[cnt] = make_tok(punct_kind, ERR_NONE, 32'(byte_offset_reg),
                                              8'd1, 64'd0, 64'd0);
                        cnt = cnt + 2'd1;
                    end else begin
                        slots[cnt] = make_tok(KIND_ERROR, ERR_UNEXPECTED,
                                              32'(byte_offset_reg), 8'd1, 64'd0, 64'd0);
                        cnt = cnt + 2'd1;
                        mode_next = MODE_ERR;
                    end
                end
            end

            if (byte_offset_reg != OFFSET_MAX) begin
                byte_offset_next = byte_offset_reg + OFFSET_BITS'(1);
            end
        end

        if (item.ends_formula) begin
            fin_code = ERR_NONE;
            if (mode_next == MODE_ELEM) begin
                slots[cnt] = make_tok(KIND_ELEMENT, ERR_NONE, 32'(token_start_next),
                                      run_length_next, 64'(letters_kept_next), 64'd0);
                cnt = cnt + 2'd1;
                mode_next = MODE_IDLE;
            end else if (mode_next == MODE_NUM) begin
                if (value_overflowed_next) begin
                    fin_code = ERR_OVERFLOW;
                end else if (value_accum_next == 64'd0) begin
                    fin_code = ERR_ZERO;
                end else if (first_digit_zero_next) begin
                    fin_code = ERR_LEADING_ZERO;
                end
                if (fin_code != ERR_NONE) begin
                    slots[cnt] = make_tok(KIND_ERROR, fin_code, 32'(token_start_next),
                                          run_length_next, 64'd0, 64'd0);
                    mode_next = MODE_ERR;
                end else begin
                    slots[cnt] = make_tok(KIND_NUMBER, ERR_NONE, 32'(token_start_next),
                                          run_length_next, 64'd0, value_accum_next);
                    mode_next = MODE_IDLE;
                end
                cnt = cnt + 2'd1;
            end

            if (mode_next != MODE_ERR) begin
                if (byte_offset_next == '0) begin
                    slots[cnt] = make_tok(KIND_ERROR, ERR_EMPTY, 32'd0, 8'd0, 64'd0, 64'd0);
                end else begin
                    slots[cnt] = make_tok(KIND_END, ERR_NONE, 32'(byte_offset_next),
                                          8'd0, 64'd0, 64'd0);
                end
                cnt = cnt + 2'd1;
            end

            // The formula is over: everything returns to its reset value.
            mode_next             = MODE_IDLE;
            byte_offset_next      = '0;
            token_start_next      = '0;
            run_length_next       = 8'd0;
            letters_kept_next     = '0;
            value_accum_next      = 64'd0;
            first_digit_zero_next = 1'b0;
            value_overflowed_next = 1'b0;
        end

        if (cnt != 2'd0) begin
            slots[2'(cnt - 2'd1)].last_of_run = 1'b1;
        end

        bundle.count = cnt;
        bundle.slot  = slots;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg             <= MODE_IDLE;
            byte_offset_reg      <= '0;
            token_start_reg      <= '0;
            run_length_reg       <= 8'd0;
            letters_kept_reg     <= '0;
            value_accum_reg      <= 64'd0;
            first_digit_zero_reg <= 1'b0;
            value_overflowed_reg <= 1'b0;
        end else if (take) begin
            mode_reg             <= mode_next;
            byte_offset_reg      <= byte_offset_next;
            token_start_reg      <= token_start_next;
            run_length_reg       <= run_length_next;
            letters_kept_reg     <= letters_kept_next;
            value_accum_reg      <= value_accum_next;
            first_digit_zero_reg <= first_digit_zero_next;
            value_overflowed_reg <= value_overflowed_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/cfl_outq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cfl_outq (
    input  logic             clk,
    input  logic             rst_n,
    input  cfl_pkg::bundle_t bundle,
    input  logic             load,
    output logic             room,
    output logic             token_valid,
    input  logic             token_stall,
    output cfl_pkg::token_t  token
);

    import cfl_pkg::*;

    logic [COUNT_BITS-1:0]    count_reg, count_next;
    token_t [MAX_RESULTS-1:0] slot_reg, slot_next;
    logic                     drain;

    assign token_valid = (count_reg != '0);
    assign token       = slot_reg[0];
    assign drain       = token_valid && !token_stall;

    // A bundle fits an empty queue or one whose last result leaves now.
    assign room = (count_reg == '0) || (count_reg == COUNT_BITS'(1) && !token_stall);

    always_comb begin
        count_next = count_reg;
        slot_next  = slot_reg;
        if (load) begin
            count_next = bundle.count;
            slot_next  = bundle.slot;
        end else if (drain) begin
            count_next = count_reg - COUNT_BITS'(1);
            slot_next  = {token_t'('0), slot_reg[MAX_RESULTS-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        slot_reg <= slot_next;
    end

endmodule

`default_nettype wire

// ===== tb/tb_chemical_formula_lexer_unit.sv =====
`timescale 1ns / 1ps

module tb_chemical_formula_lexer_unit;

    import cfl_pkg::*;

    localparam int OFFSET_BITS   = 16;
    localparam int ELEM_CHARS    = 3;
    localparam logic [15:0] OFFSET_MAX = 16'((1 << OFFSET_BITS) - 1);

    localparam int STIM_ITEMS    = 360;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int PRINT_LIMIT   = 100;

    // Lexer modes of the predictor. A formula that has hit an error sits in
    // LEX_DROPPING until its end.
    typedef enum logic [1:0] {
        LEX_IDLE,
        LEX_ELEMENT,
        LEX_NUMBER,
        LEX_DROPPING
    } lex_mode_e;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_stall;
    lex_item_t  item = '0;
    logic       token_valid;
    logic       token_stall = 1'b0;
    token_t     token;

    // Stimulus and scoreboard storage.
    lex_item_t    pending_items[$];
    logic [7:0]   formula_bytes[$];
    token_t       expected_tokens[$];
    int unsigned  stim_count = 0;
    int unsigned  issued_items = 0;
    int unsigned  phase_len = 1;
    int unsigned  mismatch_count = 0;
    int unsigned  cycle_count = 0;

    // Predictor state: a private copy of what the lexer holds between beats.
    lex_mode_e    lx_mode = LEX_IDLE;
    logic [15:0]  lx_offset = '0;
    logic [15:0]  lx_start = '0;
    logic [7:0]   lx_len = '0;
    logic [23:0]  lx_letters = '0;
    logic [63:0]  lx_value = '0;
    logic         lx_lead_zero = 1'b0;
    logic         lx_overflow = 1'b0;

    // The newest predicted token is held back one step so that the final
    // token of a beat can be marked as the last of its run.
    token_t       staged;
    logic         staged_full = 1'b0;

    chemical_formula_lexer_unit #(
        .OFFSET_BITS   (OFFSET_BITS),
        .ELEMENT_CHARS (ELEM_CHARS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token       (token)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic is_space(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_upper(logic [7:0] c);
        return c >= 8'h41 && c <= 8'h5A;
    endfunction

    function automatic logic is_lower(logic [7:0] c);
        return c >= 8'h61 && c <= 8'h7A;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_ZERO + 8'd9;
    endfunction

    function automatic void clear_lexer();
        lx_mode      = LEX_IDLE;
        lx_offset    = '0;
        lx_start     = '0;
        lx_len       = '0;
        lx_letters   = '0;
        lx_value     = '0;
        lx_lead_zero = 1'b0;
        lx_overflow  = 1'b0;
    endfunction

    function automatic void stage_token(logic [3:0] kind, logic [2:0] code,
                                        logic [15:0] offset, logic [7:0] len,
                                        logic [23:0] text, logic [63:0] value);
        if (staged_full)
            expected_tokens.push_back(staged);
        staged              = '0;
        staged.token_kind   = kind;
        staged.error_code   = code;
        staged.start_offset = offset;
        staged.token_length = len;
        staged.element_text = text;
        staged.number_value = value;
        staged_full         = 1'b1;
    endfunction

    // Only the first few letters of an element are kept, first letter in the
    // high byte.
    function automatic void keep_letter(logic [7:0] c);
        if (lx_len < ELEM_CHARS)
            lx_letters = lx_letters | (24'(c) << (8 * (ELEM_CHARS - 1 - lx_len)));
    endfunction

    // Once the value would pass 64 bits it is frozen and only the flag counts.
    function automatic void add_digit(logic [7:0] c);
        logic [63:0] d;
        d = 64'(c - CH_ZERO);
        if (!lx_overflow)
        begin
            if (lx_value > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10)
                lx_overflow = 1'b1;
            else
                lx_value = lx_value * 64'd10 + d;
        end
    endfunction

    // Closes an element or number in progress. A number is judged here:
    // overflow first, then a zero value, then a leading zero.
    function automatic void close_token();
        logic [2:0] code;
        if (lx_mode == LEX_ELEMENT)
        begin
            stage_token(KIND_ELEMENT, ERR_NONE, lx_start, lx_len, lx_letters, '0);
            lx_mode = LEX_IDLE;
        end
        else if (lx_mode == LEX_NUMBER)
        begin
            code = ERR_NONE;
            if (lx_overflow)
                code = ERR_OVERFLOW;
            else if (lx_value == 0)
                code = ERR_ZERO;
            else if (lx_lead_zero)
                code = ERR_LEADING_ZERO;
            if (code != ERR_NONE)
            begin
                stage_token(KIND_ERROR, code, lx_start, lx_len, '0, '0);
                lx_mode = LEX_DROPPING;
            end
            else
            begin
                stage_token(KIND_NUMBER, ERR_NONE, lx_start, lx_len, '0, lx_value);
                lx_mode = LEX_IDLE;
            end
        end
    endfunction

    // Works out every token one accepted beat causes and queues them.
    function automatic void predict_tokens(lex_item_t beat);
        logic [7:0] c;
        logic [3:0] sym_kind;
        c = beat.char_byte;
        staged_full = 1'b0;
        if (!beat.no_char)
        begin
            if (lx_mode == LEX_ELEMENT && is_lower(c))
            begin
                keep_letter(c);
                if (lx_len != 8'hFF)
                    lx_len = lx_len + 8'd1;
            end
            else if (lx_mode == LEX_NUMBER && is_digit(c))
            begin
                add_digit(c);
                if (lx_len != 8'hFF)
                    lx_len = lx_len + 8'd1;
            end
            else
            begin
                close_token();
                if (lx_mode == LEX_IDLE)
                begin
                    if (is_space(c))
                    begin
                        stage_token(KIND_ERROR, ERR_WHITESPACE, lx_offset, 8'd1, '0, '0);
                        lx_mode = LEX_DROPPING;
                    end
                    else if (is_upper(c))
                    begin
                        lx_start   = lx_offset;
                        lx_len     = '0;
                        lx_letters = '0;
                        keep_letter(c);
                        lx_len     = 8'd1;
                        lx_mode    = LEX_ELEMENT;
                    end
                    else if (is_digit(c))
                    begin
                        lx_start     = lx_offset;
                        lx_len       = 8'd1;
                        lx_value     = '0;
                        lx_overflow  = 1'b0;
                        lx_lead_zero = (c == CH_ZERO);
                        add_digit(c);
                        lx_mode      = LEX_NUMBER;
                    end
                    else
                    begin
                        case (c)
                            CH_LPAREN:   sym_kind = KIND_LPAREN;
                            CH_RPAREN:   sym_kind = KIND_RPAREN;
                            CH_LBRACKET: sym_kind = KIND_LBRACKET;
                            CH_RBRACKET: sym_kind = KIND_RBRACKET;
                            CH_STAR:     sym_kind = KIND_STAR;
                            default:     sym_kind = KIND_ERROR;
                        endcase
                        if (sym_kind == KIND_ERROR)
                        begin
                            stage_token(KIND_ERROR, ERR_UNEXPECTED, lx_offset, 8'd1, '0, '0);
                            lx_mode = LEX_DROPPING;
                        end
                        else
                            stage_token(sym_kind, ERR_NONE, lx_offset, 8'd1, '0, '0);
                    end
                end
            end
            if (lx_offset != OFFSET_MAX)
                lx_offset = lx_offset + 16'd1;
        end
        if (beat.ends_formula)
        begin
            close_token();
            if (lx_mode != LEX_DROPPING)
            begin
                if (lx_offset == 0)
                    stage_token(KIND_ERROR, ERR_EMPTY, '0, '0, '0, '0);
                else
                    stage_token(KIND_END, ERR_NONE, lx_offset, '0, '0, '0);
            end
            clear_lexer();
        end
        if (staged_full)
        begin
            staged.last_of_run = 1'b1;
            expected_tokens.push_back(staged);
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic compare_field(string field, logic [63:0] got, logic [63:0] want,
                                 string where);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, want %0h (%s)", field, got, want, where));
    endtask

    // Every accepted token is matched against the oldest prediction.
    task automatic check_token(token_t got);
        token_t want;
        string  where;
        if (expected_tokens.size() == 0)
            report_mismatch($sformatf("unpredicted token, kind %0d at offset %0d",
                                      got.token_kind, got.start_offset));
        else
        begin
            want  = expected_tokens.pop_front();
            where = $sformatf("expected kind %0d at offset %0d",
                              want.token_kind, want.start_offset);
            compare_field("token_kind",   got.token_kind,   want.token_kind,   where);
            compare_field("error_code",   got.error_code,   want.error_code,   where);
            compare_field("start_offset", got.start_offset, want.start_offset, where);
            compare_field("token_length", got.token_length, want.token_length, where);
            compare_field("element_text", got.element_text, want.element_text, where);
            compare_field("number_value", got.number_value, want.number_value, where);
            compare_field("last_of_run",  got.last_of_run,  want.last_of_run,  where);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------

    // Beats that carry neither a character nor an end are filler and do not
    // count toward the stimulus total.
    task automatic push_item(logic [7:0] c, logic ends, logic none);
        lex_item_t beat;
        beat.char_byte    = c;
        beat.ends_formula = ends;
        beat.no_char      = none;
        pending_items.push_back(beat);
        if (!none || ends)
            stim_count++;
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++)
            formula_bytes.push_back(s[i]);
    endtask

    // Turns the bytes gathered so far into beats. The end either rides on
    // the last character or comes as a beat of its own without a character.
    task automatic queue_formula(logic end_alone, logic noisy);
        int last;
        last = formula_bytes.size() - 1;
        if (last < 0)
            end_alone = 1'b1;
        for (int i = 0; i <= last; i++)
        begin
            if (noisy && $urandom_range(24) == 0)
                push_item(8'($urandom()), 1'b0, 1'b1);
            push_item(formula_bytes[i], !end_alone && i == last, 1'b0);
        end
        if (end_alone)
            push_item(8'($urandom()), 1'b1, 1'b1);
        formula_bytes.delete();
    endtask

    function automatic logic [7:0] lower_char();
        return 8'(8'h61 + $urandom_range(25));
    endfunction

    function automatic logic [7:0] digit_char(int unsigned lo);
        return 8'(CH_ZERO + $urandom_range(9, lo));
    endfunction

    // One token of random content. Without faults only well-formed tokens
    // come out; with faults, bad numbers, whitespace, stray lowercase and
    // arbitrary bytes join in.
    task automatic put_random_token(logic faults);
        int unsigned pick;
        pick = faults ? $urandom_range(139) : $urandom_range(99);
        if (pick < 35)
        begin
            formula_bytes.push_back(8'(8'h41 + $urandom_range(25)));
            repeat ($urandom_range(3))
                formula_bytes.push_back(lower_char());
        end
        else if (pick < 65)
        begin
            formula_bytes.push_back(digit_char(1));
            repeat ($urandom_range(3))
                formula_bytes.push_back(digit_char(0));
        end
        else if (pick < 95)
        begin
            case ($urandom_range(4))
                0:       formula_bytes.push_back(CH_LPAREN);
                1:       formula_bytes.push_back(CH_RPAREN);
                2:       formula_bytes.push_back(CH_LBRACKET);
                3:       formula_bytes.push_back(CH_RBRACKET);
                default: formula_bytes.push_back(CH_STAR);
            endcase
        end
        else if (pick < 100)
            put_text("18446744073709551615");
        else if (pick < 110)
        begin
            case ($urandom_range(4))
                0:       put_text("18446744073709551616");
                1:       put_text("99999999999999999999");
                2:       put_text("000");
                3:       put_text("0042");
                default: put_text("0");
            endcase
        end
        else if (pick < 118)
            formula_bytes.push_back($urandom_range(1) ? 8'h20 : 8'(8'h09 + $urandom_range(4)));
        else if (pick < 122)
            formula_bytes.push_back(lower_char());
        else
            formula_bytes.push_back(8'($urandom()));
    endtask

    // ------------------------------------------------------------------
    // Idle and stall rates: the first third of the beats has a lightly idle
    // sender and a heavily stalling receiver, the second third the reverse,
    // and the rest runs at full rate on both sides.
    // ------------------------------------------------------------------

    function automatic int unsigned send_gap_pct();
        if (issued_items < phase_len)
            return 16;
        else if (issued_items < 2 * phase_len)
            return 83;
        return 0;
    endfunction

    function automatic int unsigned recv_stall_pct();
        if (issued_items < phase_len)
            return 83;
        else if (issued_items < 2 * phase_len)
            return 16;
        return 0;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers the next pending beat whenever the current one has been
    // taken or none is on offer. A beat on offer is held until accepted.
    // The prediction is made at the edge that accepts the beat.
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else
        begin
            if (item_valid && !item_stall)
                predict_tokens(item);
            if (!item_valid || !item_stall)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_gap_pct())
                begin
                    item       <= pending_items.pop_front();
                    item_valid <= 1'b1;
                    issued_items++;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each token beat that is taken and redraws the stall
    // for the next cycle.
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            token_stall <= 1'b0;
        else
        begin
            if (token_valid && !token_stall)
                check_token(token);
            token_stall <= ($urandom_range(99) < recv_stall_pct());
        end
    end

    // Watchdog against a hang anywhere in the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of test
    // ------------------------------------------------------------------

    initial
    begin
        logic faulty;

        // Empty formula: an end with no character gives the empty error.
        queue_formula(1'b1, 1'b0);
        // A beat with neither character nor end must cause nothing.
        push_item(8'hA5, 1'b0, 1'b1);
        // Element longer than the kept letters, ended by a digit; the number
        // is ended by a closing parenthesis, and the end on that same beat adds
        // End, so one beat causes three tokens.
        put_text("Xyzw2)");
        queue_formula(1'b0, 1'b0);
        // Every single-character token but the closing parenthesis.
        put_text("([]*");
        queue_formula(1'b0, 1'b0);
        // Element ended by whitespace: the token, then the error; the end
        // beat after the error gives nothing.
        put_text("H ");
        queue_formula(1'b1, 1'b0);
        // Lowercase letter with no element before it.
        put_text("a");
        queue_formula(1'b0, 1'b0);
        // Leading zero.
        put_text("07");
        queue_formula(1'b0, 1'b0);
        // Zero value; the ending byte, all ones, is dropped.
        put_text("00");
        formula_bytes.push_back(8'hFF);
        queue_formula(1'b0, 1'b0);
        // Number closed by the end of the formula.
        put_text("9");
        queue_formula(1'b0, 1'b0);
        // The all-zero byte is an unexpected character.
        formula_bytes.push_back(8'h00);
        queue_formula(1'b0, 1'b0);

        // Random formulas: most well-formed, about a quarter with faults.
        while (stim_count < STIM_ITEMS)
        begin
            faulty = ($urandom_range(3) == 0);
            repeat ($urandom_range(6))
                put_random_token(faulty);
            queue_formula($urandom_range(1), 1'b1);
        end
        phase_len = pending_items.size() / 3;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every beat has been taken and every token has arrived,
        // then give the block time to show any stray token.
        do
            @(posedge clk);
        while (pending_items.size() != 0 || item_valid || expected_tokens.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/cfl_pkg.sv
hdl/cfl_core.sv
hdl/cfl_outq.sv
hdl/chemical_formula_lexer_unit.sv
tb/tb_chemical_formula_lexer_unit.sv
